FILE: hdl/bgd_pkg.sv
// Shared types, constants and register codes for the button gesture detector.
package bgd_pkg;

    localparam int BUTTON_W        = 3;
    localparam int BUTTON_SLOTS    = 1 << BUTTON_W;
    localparam int NUM_BUTTONS_DEF = 8;
    localparam int MASK_W          = 8;
    localparam int TICK_W          = 16;
    localparam int DB_W            = 4;
    localparam int CNT_W           = 4;
    localparam int EV_W            = 3;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    localparam logic [DB_W-1:0]   DEBOUNCE_RST = DB_W'(3);
    localparam logic [TICK_W-1:0] SHORT_RST    = TICK_W'(60);
    localparam logic [TICK_W-1:0] LONG_RST     = TICK_W'(200);
    localparam logic [MASK_W-1:0] ACTIVE_RST   = '0;
    localparam logic [MASK_W-1:0] ENABLE_RST   = '1;
    localparam logic [TICK_W-1:0] HOLD_MAX     = '1;
    localparam logic [CNT_W-1:0]  CLICK_MAX    = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 3'd0,
        CFG_SHORT    = 3'd1,
        CFG_LONG     = 3'd2,
        CFG_ACTIVE   = 3'd3,
        CFG_ENABLE   = 3'd4
    } cfg_index_t;

    typedef enum logic [EV_W-1:0] {
        EV_NONE   = 3'd0,
        EV_DOWN   = 3'd1,
        EV_UP     = 3'd2,
        EV_REPEAT = 3'd3,
        EV_SINGLE = 3'd4,
        EV_DOUBLE = 3'd5,
        EV_LSTART = 3'd6,
        EV_LHOLD  = 3'd7
    } event_t;

    typedef enum logic [2:0] {
        G_IDLE    = 3'd0,
        G_PRESS   = 3'd1,
        G_RELEASE = 3'd2,
        G_REPRESS = 3'd3,
        G_LONG    = 3'd5
    } gstate_t;

    typedef struct packed {
        logic [BUTTON_W-1:0] button_index;
        logic                pin_level;
    } item_t;

    typedef struct packed {
        logic [BUTTON_W-1:0] result_button;
        event_t              fired_event;
        event_t              status_event;
        logic [CNT_W-1:0]    press_count;
    } result_t;

    typedef struct packed {
        logic [DB_W-1:0]   settle_len;
        logic [TICK_W-1:0] click_gap;
        logic [TICK_W-1:0] long_len;
        logic [MASK_W-1:0] active_level_mask;
        logic [MASK_W-1:0] enable_mask;
    } cfg_t;

    typedef struct packed {
        gstate_t           gesture_state;
        logic [TICK_W-1:0] hold_ticks;
        logic [DB_W-1:0]   debounce_count;
        logic              stable_level;
        logic [CNT_W-1:0]  click_count;
        event_t            event_reg;
    } btn_state_t;

endpackage

FILE: hdl/bgd_state_bank.sv
// Per-button state registers with one combinational read and one write port.
module bgd_state_bank
    import bgd_pkg::*;
#(
    parameter int DEPTH = NUM_BUTTONS_DEF,
    parameter int IDX_W = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] raddr,
    output btn_state_t       rdata,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  btn_state_t       wdata
);

    btn_state_t bank_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                bank_reg[i].gesture_state  <= G_IDLE;
                bank_reg[i].hold_ticks     <= '0;
                bank_reg[i].debounce_count <= '0;
                // inactive level under the reset polarity mask
                bank_reg[i].stable_level   <= 1'b1;
                bank_reg[i].click_count    <= '0;
                bank_reg[i].event_reg      <= EV_NONE;
            end
        end
        else if (we)
        begin
            bank_reg[waddr] <= wdata;
        end
    end

    assign rdata = bank_reg[raddr];

endmodule

FILE: hdl/bgd_step.sv
// Debounce and gesture update for one button tick, with the result it reports.
module bgd_step
    import bgd_pkg::*;
(
    input  cfg_t       cfg,
    input  item_t      item,
    input  logic       in_range,
    input  btn_state_t cur,
    output btn_state_t nxt,
    output logic       commit,
    output result_t    res
);

    logic   active;
    logic   enabled;
    logic   pressed;
    event_t fired;

    assign active  = cfg.active_level_mask[item.button_index];
    assign enabled = cfg.enable_mask[item.button_index];
    assign commit  = in_range && enabled;

    always_comb
    begin
        nxt   = cur;
        fired = EV_NONE;

        if (cur.gesture_state != G_IDLE && cur.hold_ticks != HOLD_MAX)
        begin
            nxt.hold_ticks = cur.hold_ticks + TICK_W'(1);
        end

        if (item.pin_level != cur.stable_level)
        begin
            nxt.debounce_count = cur.debounce_count + DB_W'(1);
            if (nxt.debounce_count >= cfg.settle_len)
            begin
                nxt.stable_level   = item.pin_level;
                nxt.debounce_count = '0;
            end
        end
        else
        begin
            nxt.debounce_count = '0;
        end

        pressed = (nxt.stable_level == active);

        case (cur.gesture_state)
            G_IDLE:
            begin
                if (pressed)
                begin
                    nxt.event_reg     = EV_DOWN;
                    fired             = EV_DOWN;
                    nxt.hold_ticks    = '0;
                    nxt.click_count   = CNT_W'(1);
                    nxt.gesture_state = G_PRESS;
                end
                else
                begin
                    nxt.event_reg = EV_NONE;
                end
            end
            G_PRESS:
            begin
                if (!pressed)
                begin
                    nxt.event_reg     = EV_UP;
                    fired             = EV_UP;
                    nxt.hold_ticks    = '0;
                    nxt.gesture_state = G_RELEASE;
                end
                else if (nxt.hold_ticks > cfg.long_len)
                begin
                    nxt.event_reg     = EV_LSTART;
                    fired             = EV_LSTART;
                    nxt.gesture_state = G_LONG;
                end
            end
            G_RELEASE:
            begin
                if (pressed)
                begin
                    nxt.event_reg = EV_DOWN;
                    if (cur.click_count != CLICK_MAX)
                    begin
                        nxt.click_count = cur.click_count + CNT_W'(1);
                    end
                    fired             = EV_REPEAT;
                    nxt.hold_ticks    = '0;
                    nxt.gesture_state = G_REPRESS;
                end
                else if (nxt.hold_ticks > cfg.click_gap)
                begin
                    // third and later clicks end the sequence silently
                    if (cur.click_count == CNT_W'(1))
                    begin
                        nxt.event_reg = EV_SINGLE;
                        fired         = EV_SINGLE;
                    end
                    else if (cur.click_count == CNT_W'(2))
                    begin
                        nxt.event_reg = EV_DOUBLE;
                        fired         = EV_DOUBLE;
                    end
                    nxt.gesture_state = G_IDLE;
                end
            end
            G_REPRESS:
            begin
                if (!pressed)
                begin
                    nxt.event_reg = EV_UP;
                    fired         = EV_UP;
                    if (nxt.hold_ticks < cfg.click_gap)
                    begin
                        nxt.hold_ticks    = '0;
                        nxt.gesture_state = G_RELEASE;
                    end
                    else
                    begin
                        nxt.gesture_state = G_IDLE;
                    end
                end
                else if (nxt.hold_ticks > cfg.click_gap)
                begin
                    nxt.gesture_state = G_IDLE;
                end
            end
            G_LONG:
            begin
                if (pressed)
                begin
                    nxt.event_reg = EV_LHOLD;
                    fired         = EV_LHOLD;
                end
                else
                begin
                    nxt.event_reg     = EV_UP;
                    fired             = EV_UP;
                    nxt.gesture_state = G_IDLE;
                end
            end
            default:
            begin
                nxt.gesture_state = G_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.result_button = item.button_index;
        res.fired_event   = EV_NONE;
        res.status_event  = EV_NONE;
        res.press_count   = '0;
        if (in_range)
        begin
            if (enabled)
            begin
                res.fired_event  = fired;
                res.status_event = nxt.event_reg;
                res.press_count  = nxt.click_count;
            end
            else
            begin
                // disabled: report the held state untouched
                res.status_event = cur.event_reg;
                res.press_count  = cur.click_count;
            end
        end
    end

endmodule

FILE: hdl/button_gesture_detector.sv
// Top level: config registers, input register, state bank, step logic, result register.
//
//   Channel   Signals                         Payload
//   item      item_valid / item_ready         item_t   (button_index, pin_level)
//   result    result_valid / result_ready     result_t (button, fired, status, count)
//   config    cfg_we, cfg_index, cfg_data     register write, no wait, no read-back
//
// An accepted transaction waits in the input register while the step logic computes
// its result, which the result register takes once the result side is free.
// One transaction is accepted per cycle unless the result side stalls; state read and
// write-back of the step logic close in the same cycle, so same-button ticks may follow directly.
// Reset puts every button idle with its stable level inactive; no clearing pass.
// A stalled result holds the result register; the input register still takes
// one more transaction, then item_ready drops until the result is taken.
module button_gesture_detector
    import bgd_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // index field reaches only BUTTON_SLOTS entries
    localparam int DEPTH = (NUM_BUTTONS < BUTTON_SLOTS) ? NUM_BUTTONS : BUTTON_SLOTS;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cfg_t       cfg_reg;
    logic       ivalid_reg;
    item_t      item_reg;
    logic       ovalid_reg;
    result_t    result_reg;

    logic             advance;
    logic             in_range;
    logic [IDX_W-1:0] sel;
    btn_state_t       cur_state;
    btn_state_t       nxt_state;
    logic             commit;
    result_t          step_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_len        <= DEBOUNCE_RST;
            cfg_reg.click_gap         <= SHORT_RST;
            cfg_reg.long_len          <= LONG_RST;
            cfg_reg.active_level_mask <= ACTIVE_RST;
            cfg_reg.enable_mask       <= ENABLE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE: cfg_reg.settle_len        <= cfg_data[DB_W-1:0];
                CFG_SHORT:    cfg_reg.click_gap         <= cfg_data[TICK_W-1:0];
                CFG_LONG:     cfg_reg.long_len          <= cfg_data[TICK_W-1:0];
                CFG_ACTIVE:   cfg_reg.active_level_mask <= cfg_data[MASK_W-1:0];
                CFG_ENABLE:   cfg_reg.enable_mask       <= cfg_data[MASK_W-1:0];
                default:      ; // drop writes beyond the register list
            endcase
        end
    end

    assign advance    = ivalid_reg && (!ovalid_reg || result_ready);
    assign item_ready = !ivalid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivalid_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                ivalid_reg <= item_valid;
            end
            if (advance)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= step_res;
        end
    end

    assign in_range = 32'(item_reg.button_index) < NUM_BUTTONS;
    assign sel      = IDX_W'(item_reg.button_index);

    bgd_state_bank #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_bank (
        .clk   (clk),
        .rst_n (rst_n),
        .raddr (sel),
        .rdata (cur_state),
        .we    (advance && commit),
        .waddr (sel),
        .wdata (nxt_state)
    );

    bgd_step u_step (
        .cfg      (cfg_reg),
        .item     (item_reg),
        .in_range (in_range),
        .cur      (cur_state),
        .nxt      (nxt_state),
        .commit   (commit),
        .res      (step_res)
    );

    assign result_valid = ovalid_reg;
    assign result       = result_reg;

endmodule

FILE: hdl/bgd_checker.sv
// Port-level checker for the button gesture detector, bound to the top level.
module bgd_checker
    import bgd_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    // a stalled result holds until the transaction completes
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed or dropped while stalled");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !result_valid)
        else $error("result valid during reset");

    a_repeat_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.fired_event == EV_REPEAT |->
            result.status_event == EV_DOWN && result.press_count > CNT_W'(1))
        else $error("repeat press without down status");

    a_fired_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.fired_event != EV_NONE && result.fired_event != EV_REPEAT |->
            result.status_event == result.fired_event)
        else $error("fired event not in status register");

    a_click_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.fired_event == EV_DOWN || result.fired_event == EV_SINGLE) |->
            result.press_count == CNT_W'(1))
        else $error("first press or single click with wrong press count");

endmodule

bind button_gesture_detector bgd_checker u_bgd_checker (.*);

FILE: bench/button_gesture_detector_tb.sv
// Self-checking testbench for the button gesture detector: directed and random scan ticks checked per result.
module button_gesture_detector_tb
    import bgd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    class gesture_tracker;
        logic [DB_W-1:0]   settle_len;
        logic [TICK_W-1:0] click_gap;
        logic [TICK_W-1:0] long_len;
        logic [MASK_W-1:0] active_mask;
        logic [MASK_W-1:0] enable_mask;
        btn_state_t        buttons [BUTTON_SLOTS];
        result_t           gesture_reports [$];
        int                mismatches;

        function new();
            settle_len  = DEBOUNCE_RST;
            click_gap   = SHORT_RST;
            long_len    = LONG_RST;
            active_mask = ACTIVE_RST;
            enable_mask = ENABLE_RST;
            mismatches  = 0;
            for (int b = 0; b < BUTTON_SLOTS; b++)
            begin
                buttons[b].gesture_state  = G_IDLE;
                buttons[b].hold_ticks     = '0;
                buttons[b].debounce_count = '0;
                buttons[b].stable_level   = ~ACTIVE_RST[b];
                buttons[b].click_count    = '0;
                buttons[b].event_reg      = EV_NONE;
            end
        endfunction

        function void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DEBOUNCE: settle_len  = data[DB_W-1:0];
                CFG_SHORT:    click_gap   = data;
                CFG_LONG:     long_len    = data;
                CFG_ACTIVE:   active_mask = data[MASK_W-1:0];
                CFG_ENABLE:   enable_mask = data[MASK_W-1:0];
                default:      ;
            endcase
        endfunction

        // Advance one button by one scan tick and return the event it reports.
        function result_t advance_button(item_t it);
            result_t    r;
            btn_state_t s;
            logic       pressed;
            int         b;
            b = it.button_index;
            s = buttons[b];
            r.result_button = it.button_index;
            r.fired_event   = EV_NONE;
            if (!enable_mask[b])
            begin
                r.status_event = s.event_reg;
                r.press_count  = s.click_count;
                return r;
            end
            if (s.gesture_state != G_IDLE && s.hold_ticks != HOLD_MAX)
                s.hold_ticks++;
            if (it.pin_level != s.stable_level)
            begin
                s.debounce_count++;
                // a zero threshold lets the first differing sample through
                if (s.debounce_count >= settle_len)
                begin
                    s.stable_level   = it.pin_level;
                    s.debounce_count = '0;
                end
            end
            else
                s.debounce_count = '0;
            pressed = (s.stable_level == active_mask[b]);
            case (s.gesture_state)
                G_IDLE:
                begin
                    if (pressed)
                    begin
                        s.event_reg     = EV_DOWN;
                        r.fired_event   = EV_DOWN;
                        s.hold_ticks    = '0;
                        s.click_count   = CNT_W'(1);
                        s.gesture_state = G_PRESS;
                    end
                    else
                        s.event_reg = EV_NONE;
                end
                G_PRESS:
                begin
                    if (!pressed)
                    begin
                        s.event_reg     = EV_UP;
                        r.fired_event   = EV_UP;
                        s.hold_ticks    = '0;
                        s.gesture_state = G_RELEASE;
                    end
                    else if (s.hold_ticks > long_len)
                    begin
                        s.event_reg     = EV_LSTART;
                        r.fired_event   = EV_LSTART;
                        s.gesture_state = G_LONG;
                    end
                end
                G_RELEASE:
                begin
                    if (pressed)
                    begin
                        s.event_reg = EV_DOWN;
                        if (s.click_count != CLICK_MAX)
                            s.click_count++;
                        r.fired_event   = EV_REPEAT;
                        s.hold_ticks    = '0;
                        s.gesture_state = G_REPRESS;
                    end
                    else if (s.hold_ticks > click_gap)
                    begin
                        // third and later clicks time out silently
                        if (s.click_count == CNT_W'(1))
                        begin
                            s.event_reg   = EV_SINGLE;
                            r.fired_event = EV_SINGLE;
                        end
                        else if (s.click_count == CNT_W'(2))
                        begin
                            s.event_reg   = EV_DOUBLE;
                            r.fired_event = EV_DOUBLE;
                        end
                        s.gesture_state = G_IDLE;
                    end
                end
                G_REPRESS:
                begin
                    if (!pressed)
                    begin
                        s.event_reg   = EV_UP;
                        r.fired_event = EV_UP;
                        if (s.hold_ticks < click_gap)
                        begin
                            s.hold_ticks    = '0;
                            s.gesture_state = G_RELEASE;
                        end
                        else
                            s.gesture_state = G_IDLE;
                    end
                    else if (s.hold_ticks > click_gap)
                        s.gesture_state = G_IDLE;
                end
                G_LONG:
                begin
                    if (pressed)
                    begin
                        s.event_reg   = EV_LHOLD;
                        r.fired_event = EV_LHOLD;
                    end
                    else
                    begin
                        s.event_reg     = EV_UP;
                        r.fired_event   = EV_UP;
                        s.gesture_state = G_IDLE;
                    end
                end
                default: s.gesture_state = G_IDLE;
            endcase
            buttons[b]     = s;
            r.status_event = s.event_reg;
            r.press_count  = s.click_count;
            return r;
        endfunction

        function void note_tick(item_t it);
            gesture_reports = {gesture_reports, advance_button(it)};
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (gesture_reports.size() == 0)
            begin
                $error("result for button %0d arrived with nothing pending", got.result_button);
                mismatches++;
                return;
            end
            want = gesture_reports.pop_front();
            if (got.result_button !== want.result_button)
            begin
                $error("result_button expected %0d got %0d", want.result_button,
                       got.result_button);
                mismatches++;
            end
            if (got.fired_event !== want.fired_event)
            begin
                $error("fired_event expected %0d got %0d", want.fired_event, got.fired_event);
                mismatches++;
            end
            if (got.status_event !== want.status_event)
            begin
                $error("status_event expected %0d got %0d", want.status_event,
                       got.status_event);
                mismatches++;
            end
            if (got.press_count !== want.press_count)
            begin
                $error("press_count expected %0d got %0d", want.press_count, got.press_count);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    item_t                 tick_in;
    logic                  result_valid;
    logic                  result_ready;
    result_t               report_out;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gesture_tracker tracker = new();

    bit sender_steady;
    bit receiver_steady;
    int ready_holdoff;
    int live_ticks;

    button_gesture_detector u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (tick_in),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (report_out),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Result side: random stall before each transaction unless steady, or a long hold-off on request.
    initial
    begin
        int gap;
        result_ready = 1'b0;
        forever
        begin
            if (ready_holdoff > 0)
            begin
                gap           = ready_holdoff;
                ready_holdoff = 0;
            end
            else
                gap = receiver_steady ? 0 : $urandom_range(0, 3);
            @(negedge clk);
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (result_valid !== 1'b1);
            tracker.check_result(report_out);
        end
    end

    function automatic int capped(int span);
        return (span > 30) ? 30 : span;
    endfunction

    task automatic send_tick(int b, logic lvl);
        item_t it;
        int    gap;
        it.button_index = BUTTON_W'(b);
        it.pin_level    = lvl;
        gap = sender_steady ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        tick_in    <= it;
        do @(posedge clk); while (item_ready !== 1'b1);
        tracker.note_tick(it);
        if (tracker.enable_mask[b])
            live_ticks++;
    endtask

    // Hold one button's pin at a level, with stray ticks for random buttons mixed in unless steady.
    task automatic hold_level(int b, logic lvl, int count);
        for (int k = 0; k < count; k++)
        begin
            if (!sender_steady && $urandom_range(0, 9) == 0)
                send_tick($urandom_range(0, 7), 1'($urandom_range(0, 1)));
            send_tick(b, lvl);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_valid <= 1'b0;
        while (tracker.gesture_reports.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        tracker.set_register(idx, data);
    endtask

    task automatic apply_config(int db, int sh, int lg, int act, int en);
        wait_drained();
        write_reg(CFG_DEBOUNCE, CFG_DATA_W'(db));
        write_reg(CFG_SHORT, CFG_DATA_W'(sh));
        write_reg(CFG_LONG, CFG_DATA_W'(lg));
        write_reg(CFG_ACTIVE, CFG_DATA_W'(act));
        write_reg(CFG_ENABLE, CFG_DATA_W'(en));
    endtask

    // Play one gesture: a click sequence, a long press or contact bounce on a random
    // button, or plain noise on random buttons.
    task automatic play_gesture();
        int   b;
        int   kind;
        int   presses;
        int   db;
        int   sh;
        logic p;
        b    = $urandom_range(0, 7);
        p    = tracker.active_mask[b];
        db   = (tracker.settle_len == 0) ? 1 : tracker.settle_len;
        sh   = capped(tracker.click_gap);
        kind = $urandom_range(0, 9);
        if (kind <= 5)
        begin
            // long click runs only where debounce is short, to keep the run small
            presses = (kind == 5) ? $urandom_range(3, (db <= 4) ? 17 : 4)
                                  : $urandom_range(1, 3);
            for (int k = 0; k < presses; k++)
            begin
                hold_level(b, p, db + $urandom_range(0, sh / 2));
                if (k == presses - 1)
                    hold_level(b, ~p, db + sh + 2);
                else
                    hold_level(b, ~p, db + $urandom_range(0, sh / 2));
            end
        end
        else if (kind <= 7)
        begin
            hold_level(b, p, db + capped(tracker.long_len) + $urandom_range(1, 4));
            hold_level(b, ~p, db + sh + 2);
        end
        else if (kind == 8)
        begin
            repeat ($urandom_range(1, 2 * db + 1))
                send_tick(b, 1'($urandom_range(0, 1)));
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                send_tick($urandom_range(0, 7), 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        bit   b0_pins [21];
        int   target;
        logic p;
        b0_pins         = '{1, 0, 0, 1, 0, 0, 0, 0, 1, 1, 1, 1, 1, 1, 0,
                            0, 1, 0, 0, 0, 0};
        rst_n           = 1'b0;
        item_valid      = 1'b0;
        tick_in         = '0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        ready_holdoff   = 0;
        live_ticks      = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: button 0 turns active high while its stable level stays high,
        // then walks through double click, long press and single click.
        apply_config(0, 2, 3, 8'h01, 8'hFF);
        foreach (b0_pins[k])
            send_tick(0, b0_pins[k]);
        send_tick(7, 1'b1);
        send_tick(7, 1'b0);

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: apply_config(15, 0, 0, 8'hFF, 8'hFF);
                1: apply_config(0, 16'hFFFF, 16'hFFFF, 8'h00, 8'hA5);
                2: apply_config(1, 4, 8, 8'h3C, 8'h00);
                3: apply_config(DEBOUNCE_RST, SHORT_RST, LONG_RST, 8'h0F, 8'hFF);
                default: apply_config($urandom_range(1, 4), $urandom_range(1, 12),
                                      $urandom_range(2, 30), $urandom_range(0, 255),
                                      $urandom_range(1, 255) | $urandom_range(0, 255));
            endcase
            sender_steady   = (phase == 5 || phase == 6);
            receiver_steady = (phase == 6);
            if (phase == 5)
                ready_holdoff = 40;
            if (phase == 2)
            begin
                // every button disabled: ticks only echo held state
                repeat (16)
                    send_tick($urandom_range(0, 7), 1'($urandom_range(0, 1)));
            end
            else
            begin
                target     = 40;
                live_ticks = 0;
                while (live_ticks < target)
                    play_gesture();
            end
        end

        // Saturation: seventeen quick clicks on button 6 drive the press count to its top.
        sender_steady   = 1'b1;
        receiver_steady = 1'b1;
        apply_config(1, 8, 30, tracker.active_mask, 8'hFF);
        p = tracker.active_mask[6];
        hold_level(6, ~p, 10);
        repeat (17)
        begin
            hold_level(6, p, 1);
            hold_level(6, ~p, 1);
        end
        hold_level(6, ~p, 10);

        @(negedge clk);
        item_valid <= 1'b0;
        while (tracker.gesture_reports.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
hdl/bgd_pkg.sv
hdl/bgd_state_bank.sv
hdl/bgd_step.sv
hdl/button_gesture_detector.sv
hdl/bgd_checker.sv
bench/button_gesture_detector_tb.sv
